### hw/rtl/arpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types, codes and defaults of the arp resolver cache
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int CACHE_ENTRIES_DEF = 16;
  localparam int PENDING_DEPTH_DEF = 16;
  localparam int BCAST_ENTRIES_DEF = 16;

  localparam logic [47:0] BCAST_MAC     = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] TTL_RST       = 16'd30000;
  localparam logic [15:0] INTERVAL_RST  = 16'd5000;

  typedef enum logic [1:0] {
    FUNC_SEND  = 2'd0,
    FUNC_FRAME = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    FRM_IPV4  = 2'd0,
    FRM_ARP   = 2'd1,
    FRM_OTHER = 2'd2,
    FRM_RSVD  = 2'd3
  } frame_kind_t;

  localparam logic [1:0] ARP_OP_REQUEST = 2'd1;
  localparam logic [1:0] ARP_OP_REPLY   = 2'd2;

  typedef enum logic [1:0] {
    OUT_IPV4    = 2'd0,
    OUT_REQUEST = 2'd1,
    OUT_REPLY   = 2'd2,
    OUT_DELIVER = 2'd3
  } out_kind_t;

  typedef enum logic [1:0] {
    REG_OWN_MAC  = 2'd0,
    REG_OWN_IP   = 2'd1,
    REG_TTL      = 2'd2,
    REG_INTERVAL = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    EM_IPV4_ITEM = 3'd0,
    EM_IPV4_PEND = 3'd1,
    EM_REQUEST   = 3'd2,
    EM_REPLY     = 3'd3,
    EM_DELIVER   = 3'd4
  } emit_sel_t;

  typedef enum logic [1:0] {
    KEY_HOP  = 2'd0,
    KEY_SIP  = 2'd1,
    KEY_PEND = 2'd2
  } key_sel_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [15:0] ttl_ms;
    logic [15:0] interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] tag;
    logic [31:0] hop;
    logic [47:0] dst;
    logic [1:0]  kind;
    logic        ok;
    logic [1:0]  op;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [31:0] tip;
    logic [15:0] el;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] mac;
    logic [15:0] tag;
    logic [31:0] ip;
  } res_t;

  typedef struct packed {
    logic      load;
    logic      key_ld;
    key_sel_t  key_sel;
    logic      scan_clr;
    logic      cscan;
    logic      lscan;
    logic      bscan;
    logic      age;
    logic      tick_now;
    logic      enq;
    logic      pop;
    logic      learn_wr;
    logic      breq_wr;
    logic      emit;
    emit_sel_t emit_sel;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] kind;
    logic       ok;
    logic       addr_ok;
    logic       hit;
    logic       c_last;
    logic       b_last;
    logic       b_fire;
    logic       reply_ok;
    logic       pend_empty;
    logic       out_room;
  } sts_t;

endpackage

### hw/rtl/arpc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ctrl
// sequencer: steps the datapath through lookups, learning, flush and aging
// ----------------------------------------------------------------------------
module arpc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output arpc_pkg::cmd_t cmd,
  input  arpc_pkg::sts_t sts
);
  import arpc_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_DISP     = 17'h00002,
    S_CSCAN    = 17'h00004,
    S_CCHK     = 17'h00008,
    S_ENQ      = 17'h00010,
    S_BSCAN    = 17'h00020,
    S_BCHK     = 17'h00040,
    S_BREQ     = 17'h00080,
    S_SEND_HIT = 17'h00100,
    S_DELIV    = 17'h00200,
    S_LSCAN    = 17'h00400,
    S_LWR      = 17'h00800,
    S_REPLY    = 17'h01000,
    S_FLUSH    = 17'h02000,
    S_FL_HIT   = 17'h04000,
    S_AGE      = 17'h08000,
    S_FIN      = 17'h10000
  } state_t;

  state_t state_r, state_nxt;
  logic   flush_r, flush_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    flush_nxt = flush_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        flush_nxt = 1'b0;
        priority if (sts.func == FUNC_SEND) begin
          cmd.key_ld   = 1'b1;
          cmd.key_sel  = KEY_HOP;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_CSCAN;
        end else if (sts.func == FUNC_FRAME && sts.addr_ok && sts.kind == FRM_IPV4) begin
          state_nxt = sts.ok ? S_DELIV : S_FIN;
        end else if (sts.func == FUNC_FRAME && sts.addr_ok && sts.kind == FRM_ARP) begin
          if (sts.ok) begin
            cmd.key_ld   = 1'b1;
            cmd.key_sel  = KEY_SIP;
            cmd.scan_clr = 1'b1;
            state_nxt    = S_LSCAN;
          end else begin
            state_nxt = S_FLUSH;
          end
        end else if (sts.func == FUNC_TICK) begin
          cmd.tick_now = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_AGE;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CSCAN: begin
        cmd.cscan = 1'b1;
        if (sts.c_last) state_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (sts.hit) begin
          state_nxt = flush_r ? S_FL_HIT : S_SEND_HIT;
        end else if (flush_r) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_BSCAN;
        end else begin
          state_nxt = S_ENQ;
        end
      end
      S_ENQ: begin
        cmd.enq      = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt    = S_BSCAN;
      end
      S_BSCAN: begin
        cmd.bscan = 1'b1;
        if (sts.b_last) state_nxt = S_BCHK;
      end
      S_BCHK: begin
        state_nxt = sts.b_fire ? S_BREQ : S_FIN;
      end
      S_BREQ: begin
        if (sts.out_room) begin
          cmd.breq_wr  = 1'b1;
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_REQUEST;
          state_nxt    = S_FIN;
        end
      end
      S_SEND_HIT: begin
        if (sts.out_room) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_IPV4_ITEM;
          state_nxt    = S_FIN;
        end
      end
      S_DELIV: begin
        if (sts.out_room) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_DELIVER;
          state_nxt    = S_FIN;
        end
      end
      S_LSCAN: begin
        cmd.lscan = 1'b1;
        if (sts.c_last) state_nxt = S_LWR;
      end
      S_LWR: begin
        cmd.learn_wr = 1'b1;
        state_nxt    = sts.reply_ok ? S_REPLY : S_FLUSH;
      end
      S_REPLY: begin
        if (sts.out_room) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_REPLY;
          state_nxt    = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (sts.pend_empty) begin
          state_nxt = S_FIN;
        end else begin
          flush_nxt    = 1'b1;
          cmd.key_ld   = 1'b1;
          cmd.key_sel  = KEY_PEND;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_CSCAN;
        end
      end
      S_FL_HIT: begin
        if (sts.out_room) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_IPV4_PEND;
          cmd.pop      = 1'b1;
          state_nxt    = S_FLUSH;
        end
      end
      S_AGE: begin
        cmd.age = 1'b1;
        if (sts.c_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_room) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
    end
  end

endmodule

### hw/rtl/arpc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_dp
// datapath: cache, broadcast table, pending queue, scan unit, result stage
// ----------------------------------------------------------------------------
module arpc_dp #(
  parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF,
  parameter int PENDING_DEPTH = arpc_pkg::PENDING_DEPTH_DEF,
  parameter int BCAST_ENTRIES = arpc_pkg::BCAST_ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  arpc_pkg::cfg_t  cfg,
  input  arpc_pkg::item_t item,
  input  arpc_pkg::cmd_t  cmd,
  output arpc_pkg::sts_t  sts,
  output logic            out_valid,
  input  logic            out_stall,
  output arpc_pkg::res_t  out_res,
  output logic            out_last
);
  import arpc_pkg::*;

  localparam int CW   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int BW   = (BCAST_ENTRIES > 1) ? $clog2(BCAST_ENTRIES) : 1;
  localparam int PW   = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PCW  = $clog2(PENDING_DEPTH + 1);
  localparam int SMAX = (CACHE_ENTRIES > BCAST_ENTRIES) ? CACHE_ENTRIES : BCAST_ENTRIES;
  localparam int SW   = (SMAX > 1) ? $clog2(SMAX) : 1;

  item_t item_r;
  logic [31:0] key_r;
  logic [31:0] now_r;

  // cache
  logic [CACHE_ENTRIES-1:0] c_valid_r;
  logic [31:0] c_ip_r  [CACHE_ENTRIES];
  logic [47:0] c_mac_r [CACHE_ENTRIES];
  logic [15:0] c_ttl_r [CACHE_ENTRIES];

  // broadcast table
  logic [BCAST_ENTRIES-1:0] b_valid_r;
  logic [31:0] b_ip_r   [BCAST_ENTRIES];
  logic [31:0] b_time_r [BCAST_ENTRIES];

  // pending queue
  logic [15:0] p_tag_r [PENDING_DEPTH];
  logic [31:0] p_ip_r  [PENDING_DEPTH];
  logic [PW-1:0]  head_r;
  logic [PCW-1:0] cnt_r;

  // scan unit
  logic [SW-1:0] idx_r;
  logic          hit_r;
  logic [47:0]   hit_mac_r;
  logic          m_found_r, f_found_r;
  logic [CW-1:0] m_idx_r, f_idx_r, min_idx_r;
  logic [15:0]   min_ttl_r;
  logic          bm_found_r, bf_found_r;
  logic [BW-1:0] bm_idx_r, bf_idx_r, old_idx_r;
  logic [31:0]   bm_age_r, old_age_r;

  // result stage
  logic stg_v_r, stg_v_nxt;
  res_t stg_r, emit_res;
  logic out_v_r, out_v_nxt;
  res_t out_res_r;
  logic out_last_r;
  logic move, move_last, out_free;

  logic [CW-1:0] cidx;
  logic [BW-1:0] bidx;
  logic          c_v_i, b_v_i;
  logic [31:0]   c_ip_i, b_ip_i, b_age_i;
  logic [47:0]   c_mac_i;
  logic [15:0]   c_ttl_i;
  logic [CW-1:0] c_slot;
  logic [BW-1:0] b_slot;
  logic [PW:0]   tail_sum;
  logic [PW-1:0] tail;
  logic          pend_full;

  assign cidx    = idx_r[CW-1:0];
  assign bidx    = idx_r[BW-1:0];
  assign c_v_i   = c_valid_r[cidx];
  assign c_ip_i  = c_ip_r[cidx];
  assign c_mac_i = c_mac_r[cidx];
  assign c_ttl_i = c_ttl_r[cidx];
  assign b_v_i   = b_valid_r[bidx];
  assign b_ip_i  = b_ip_r[bidx];
  assign b_age_i = now_r - b_time_r[bidx];

  assign c_slot = m_found_r ? m_idx_r : (f_found_r ? f_idx_r : min_idx_r);
  assign b_slot = bm_found_r ? bm_idx_r : (bf_found_r ? bf_idx_r : old_idx_r);

  assign tail_sum  = (PW+1)'(head_r) + (PW+1)'(cnt_r);
  assign tail      = (tail_sum >= (PW+1)'(PENDING_DEPTH))
                   ? PW'(tail_sum - (PW+1)'(PENDING_DEPTH)) : tail_sum[PW-1:0];
  assign pend_full = (cnt_r == PCW'(PENDING_DEPTH));

  // item and key
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= item;
    if (cmd.key_ld) begin
      unique case (cmd.key_sel)
        KEY_HOP:  key_r <= item_r.hop;
        KEY_SIP:  key_r <= item_r.sip;
        KEY_PEND: key_r <= p_ip_r[head_r];
        default:  key_r <= item_r.hop;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
    end else if (cmd.tick_now) begin
      now_r <= now_r + {16'd0, item_r.el};
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      hit_r      <= 1'b0;
      m_found_r  <= 1'b0;
      f_found_r  <= 1'b0;
      bm_found_r <= 1'b0;
      bf_found_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      idx_r      <= '0;
      hit_r      <= 1'b0;
      m_found_r  <= 1'b0;
      f_found_r  <= 1'b0;
      bm_found_r <= 1'b0;
      bf_found_r <= 1'b0;
    end else begin
      if (cmd.cscan || cmd.lscan || cmd.bscan || cmd.age) idx_r <= idx_r + 1'b1;
      if (cmd.cscan && !hit_r && c_v_i && c_ip_i == key_r && c_ttl_i != 16'd0) begin
        hit_r <= 1'b1;
      end
      if (cmd.lscan) begin
        if (!m_found_r && c_v_i && c_ip_i == key_r) m_found_r <= 1'b1;
        if (!f_found_r && !c_v_i) f_found_r <= 1'b1;
      end
      if (cmd.bscan) begin
        if (!bm_found_r && b_v_i && b_ip_i == key_r) bm_found_r <= 1'b1;
        if (!bf_found_r && !b_v_i) bf_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cscan && !hit_r && c_v_i && c_ip_i == key_r && c_ttl_i != 16'd0) begin
      hit_mac_r <= c_mac_i;
    end
    if (cmd.lscan) begin
      if (!m_found_r && c_v_i && c_ip_i == key_r) m_idx_r <= cidx;
      if (!f_found_r && !c_v_i) f_idx_r <= cidx;
      if (idx_r == '0 || c_ttl_i < min_ttl_r) begin
        min_idx_r <= cidx;
        min_ttl_r <= c_ttl_i;
      end
    end
    if (cmd.bscan) begin
      if (!bm_found_r && b_v_i && b_ip_i == key_r) begin
        bm_idx_r <= bidx;
        bm_age_r <= b_age_i;
      end
      if (!bf_found_r && !b_v_i) bf_idx_r <= bidx;
      if (idx_r == '0 || b_age_i > old_age_r) begin
        old_idx_r <= bidx;
        old_age_r <= b_age_i;
      end
    end
  end

  // cache storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= '0;
    end else if (cmd.learn_wr) begin
      c_valid_r[c_slot] <= 1'b1;
    end else if (cmd.age && c_v_i && c_ttl_i <= item_r.el) begin
      c_valid_r[cidx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.learn_wr) begin
      c_ip_r[c_slot]  <= key_r;
      c_mac_r[c_slot] <= item_r.smac;
      c_ttl_r[c_slot] <= cfg.ttl_ms;
    end else if (cmd.age && c_v_i && c_ttl_i > item_r.el) begin
      c_ttl_r[cidx] <= c_ttl_i - item_r.el;
    end
  end

  // broadcast table storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= '0;
    end else if (cmd.breq_wr) begin
      b_valid_r[b_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.breq_wr) begin
      b_ip_r[b_slot]   <= key_r;
      b_time_r[b_slot] <= now_r;
    end
  end

  // pending queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.enq && !pend_full) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.pop) begin
      head_r <= (head_r == PW'(PENDING_DEPTH - 1)) ? '0 : head_r + 1'b1;
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq && !pend_full) begin
      p_tag_r[tail] <= item_r.tag;
      p_ip_r[tail]  <= key_r;
    end
  end

  // result stage: one staged result so last can be marked at the end
  always_comb begin
    emit_res = '0;
    unique case (cmd.emit_sel)
      EM_IPV4_ITEM: begin
        emit_res.kind = OUT_IPV4;
        emit_res.mac  = hit_mac_r;
        emit_res.tag  = item_r.tag;
      end
      EM_IPV4_PEND: begin
        emit_res.kind = OUT_IPV4;
        emit_res.mac  = hit_mac_r;
        emit_res.tag  = p_tag_r[head_r];
      end
      EM_REQUEST: begin
        emit_res.kind = OUT_REQUEST;
        emit_res.mac  = BCAST_MAC;
        emit_res.ip   = key_r;
      end
      EM_REPLY: begin
        emit_res.kind = OUT_REPLY;
        emit_res.mac  = item_r.smac;
        emit_res.ip   = item_r.sip;
      end
      EM_DELIVER: begin
        emit_res.kind = OUT_DELIVER;
        emit_res.tag  = item_r.tag;
      end
      default: emit_res = '0;
    endcase
  end

  assign out_free = !out_v_r || !out_stall;

  always_comb begin
    out_v_nxt = out_v_r && out_stall;
    stg_v_nxt = stg_v_r;
    move      = 1'b0;
    move_last = 1'b0;
    if (cmd.emit) begin
      move      = stg_v_r;
      stg_v_nxt = 1'b1;
    end
    if (cmd.finish && stg_v_r) begin
      move      = 1'b1;
      move_last = 1'b1;
      stg_v_nxt = 1'b0;
    end
    if (move) out_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) stg_r <= emit_res;
    if (move) begin
      out_res_r  <= stg_r;
      out_last_r <= move_last;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

  assign sts.func       = item_r.func;
  assign sts.kind       = item_r.kind;
  assign sts.ok         = item_r.ok;
  assign sts.addr_ok    = (item_r.dst == cfg.own_mac) || (item_r.dst == BCAST_MAC);
  assign sts.hit        = hit_r;
  assign sts.c_last     = (idx_r == SW'(CACHE_ENTRIES - 1));
  assign sts.b_last     = (idx_r == SW'(BCAST_ENTRIES - 1));
  assign sts.b_fire     = !bm_found_r || (bm_age_r >= {16'd0, cfg.interval_ms});
  assign sts.reply_ok   = (item_r.tip == cfg.own_ip) && (item_r.op == ARP_OP_REQUEST);
  assign sts.pend_empty = (cnt_r == '0);
  assign sts.out_room   = !stg_v_r || out_free;

endmodule

### hw/rtl/arp_resolver_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_resolver_cache
// arp resolver with mapping cache, request rate limiter and pending queue
//
//   channel | direction | handshake            | payload
//   in_     | in        | in_valid / in_stall  | func, tag, hop ip, frame and arp fields
//   out_    | out       | out_valid / out_stall| kind, dst mac, tag, target ip, last
//   apb     | in        | psel / penable       | four registers at 8*i, 64-bit data
//
// a send scans the cache and, on a miss, the broadcast table; a tick scans
// the cache to age it; an arp frame scans the cache to learn its sender if it
// parses, and once more per flushed handle; every scan steps through its table
// one entry per cycle.
// reset is synchronous; valid bits, queue pointers and clock clear at once.
// a stalled output holds the block once its staged result cannot move on.
// ----------------------------------------------------------------------------
module arp_resolver_cache #(
  parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF,
  parameter int PENDING_DEPTH = arpc_pkg::PENDING_DEPTH_DEF,
  parameter int BCAST_ENTRIES = arpc_pkg::BCAST_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_datagram_tag,
  input  logic [31:0] in_next_hop_ip,
  input  logic [47:0] in_frame_dst_mac,
  input  logic [1:0]  in_frame_kind,
  input  logic        in_parse_ok,
  input  logic [1:0]  in_arp_opcode,
  input  logic [47:0] in_sender_mac,
  input  logic [31:0] in_sender_ip,
  input  logic [31:0] in_target_ip,
  input  logic [15:0] in_elapsed_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [47:0] out_dst_mac,
  output logic [15:0] out_tag,
  output logic [31:0] out_target_ip,
  output logic        out_last
);
  import arpc_pkg::*;

  cfg_t     cfg_r;
  item_t    item;
  cmd_t     cmd;
  sts_t     sts;
  res_t     res;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_mac     <= '0;
      cfg_r.own_ip      <= '0;
      cfg_r.ttl_ms      <= TTL_RST;
      cfg_r.interval_ms <= INTERVAL_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_OWN_MAC:  cfg_r.own_mac     <= pwdata[47:0];
        REG_OWN_IP:   cfg_r.own_ip      <= pwdata[31:0];
        REG_TTL:      cfg_r.ttl_ms      <= pwdata[15:0];
        REG_INTERVAL: cfg_r.interval_ms <= pwdata[15:0];
        default:      cfg_r.own_mac     <= cfg_r.own_mac;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_OWN_MAC:  prdata = {16'd0, cfg_r.own_mac};
      REG_OWN_IP:   prdata = {32'd0, cfg_r.own_ip};
      REG_TTL:      prdata = {48'd0, cfg_r.ttl_ms};
      REG_INTERVAL: prdata = {48'd0, cfg_r.interval_ms};
      default:      prdata = '0;
    endcase
  end

  assign item.func = in_func;
  assign item.tag  = in_datagram_tag;
  assign item.hop  = in_next_hop_ip;
  assign item.dst  = in_frame_dst_mac;
  assign item.kind = in_frame_kind;
  assign item.ok   = in_parse_ok;
  assign item.op   = in_arp_opcode;
  assign item.smac = in_sender_mac;
  assign item.sip  = in_sender_ip;
  assign item.tip  = in_target_ip;
  assign item.el   = in_elapsed_ms;

  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  arpc_dp #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .PENDING_DEPTH (PENDING_DEPTH),
    .BCAST_ENTRIES (BCAST_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res),
    .out_last  (out_last)
  );

  assign out_kind      = res.kind;
  assign out_dst_mac   = res.mac;
  assign out_tag       = res.tag;
  assign out_target_ip = res.ip;

endmodule

### hw/rtl/arpc_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_check
// port-level checks of the arp resolver cache, bound to the top level
// ----------------------------------------------------------------------------
module arpc_check (
  input logic        clk,
  input logic        rst_n,
  input logic        pready,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [47:0] out_dst_mac,
  input logic [15:0] out_tag,
  input logic [31:0] out_target_ip
);
  import arpc_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted transaction did not make the block busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_tag)
      && $stable(out_dst_mac) && $stable(out_target_ip))
    else $error("stalled result changed");

  a_request_bcast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == OUT_REQUEST |-> out_dst_mac == BCAST_MAC && out_tag == 16'd0)
    else $error("arp request not broadcast");

  a_deliver_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == OUT_DELIVER |-> out_dst_mac == 48'd0 && out_target_ip == 32'd0)
    else $error("delivery carries frame fields");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind arp_resolver_cache arpc_check u_arpc_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .pready        (pready),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_dst_mac   (out_dst_mac),
  .out_tag       (out_tag),
  .out_target_ip (out_target_ip)
);
